// File: rtl/core/lae_pkg.sv
// Package for the ANSI line editor: decoded commands, decoder and sequencer states,
// event codes and byte constants. No dependencies.
`timescale 1ns / 1ps

package lae_pkg;

  // Event codes carried on event_kind
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_REDRAW  = 3'd1;
  localparam logic [2:0] EV_CHAR    = 3'd2;
  localparam logic [2:0] EV_EMPTY   = 3'd3;
  localparam logic [2:0] EV_ABANDON = 3'd4;
  localparam logic [2:0] EV_CLEAR   = 3'd5;

  // Byte constants
  localparam logic [7:0] KEY_ESC   = 8'h1b;
  localparam logic [7:0] KEY_DEL   = 8'h7f;
  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_CR    = 8'h0d;
  localparam logic [7:0] KEY_LF    = 8'h0a;
  localparam logic [7:0] KEY_CTL_A = 8'h01;
  localparam logic [7:0] KEY_CTL_C = 8'h03;
  localparam logic [7:0] KEY_CTL_E = 8'h05;
  localparam logic [7:0] KEY_CTL_L = 8'h0c;
  localparam logic [7:0] KEY_SPACE = 8'h20;
  localparam logic [7:0] KEY_LAT1  = 8'ha0;
  localparam logic [15:0] CSI_MAX  = 16'hffff;

  // Escape decoder state
  typedef enum logic [1:0] {
    ESC_TEXT = 2'd0,
    ESC_SEEN = 2'd1,
    ESC_CSI  = 2'd2
  } esc_t;

  // Decoded command for one byte
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_BKSP,
    CMD_DELETE,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_HOME,
    CMD_END,
    CMD_BACK,
    CMD_FWD,
    CMD_ENTER,
    CMD_CANCEL,
    CMD_CLRSCR
  } cmd_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_PUT,
    ST_REM_CHK,
    ST_REM_RD,
    ST_REM_WR,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_CPY_RD,
    ST_CPY_WR,
    ST_STASH_RD,
    ST_STASH_WR,
    ST_LOAD_SEL,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_EM_RD,
    ST_EM_OUT,
    ST_FIN
  } state_t;

endpackage

// File: rtl/core/ansi_line_editor_with_history.sv
// Line editor top level: sequencer, edit / stash / history memories, output register.
// Depends on lae_pkg and lae_decode.
`timescale 1ns / 1ps

// One terminal byte per item; the block takes no new byte until the previous one
// is fully handled. Cursor moves and control keys pass only through the dispatch
// and finish states. Work on the line runs through one index counter with
// registered memory reads, a read state and a second state per character: an
// insert or delete per character shifted, an up or down arrow per character
// stashed and per character recalled, and Enter per character for the repeat
// check, the history copy and the emitting. Output stalls hold the emit and finish
// states. No clearing pass is needed after reset.
module ansi_line_editor_with_history #(
  parameter int LINE_SIZE     = 64,
  parameter int HISTORY_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] key_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_kind,
  output logic [7:0] char_out,
  output logic [5:0] cursor_pos,
  output logic [5:0] line_length,
  output logic       last
);
  import lae_pkg::*;

  localparam int LW = $clog2(LINE_SIZE);
  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int AW = $clog2(HISTORY_DEPTH * LINE_SIZE);

  // Configuration
  logic [8:0] term_w;
  logic [6:0] prompt_w;
  always_ff @(posedge clk) begin
    if (rst) begin
      term_w   <= 9'd80;
      prompt_w <= 7'd10;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) term_w <= cfg_data;
      else prompt_w <= cfg_data[6:0];
    end
  end

  // Room for the line
  logic [9:0]    room_raw;
  logic [LW-1:0] room;
  always_comb begin
    room_raw = ({1'b0, term_w} > ({3'b000, prompt_w} + 10'd1))
             ? ({1'b0, term_w} - {3'b000, prompt_w} - 10'd1) : 10'd1;
    room = (room_raw < 10'(LINE_SIZE - 1)) ? room_raw[LW-1:0] : LW'(LINE_SIZE - 1);
  end

  // Decoder
  logic  accept;
  cmd_t  dec_cmd;
  assign accept = in_valid && in_ready;

  lae_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .key_byte (key_byte),
    .cmd      (dec_cmd)
  );

  // Sequencer and datapath registers
  state_t        state, state_next;
  cmd_t          cmd;
  logic [7:0]    kbyte;
  logic [LW-1:0] cur, cur_next;
  logic [LW-1:0] len, len_next;
  logic [LW-1:0] idx, idx_next;
  logic [LW-1:0] ldn, ldn_next;
  logic [LW-1:0] stash_len, stash_len_next;
  logic [HW:0]   depth, depth_next;
  logic [HW:0]   hcount, hcount_next;
  logic [HW-1:0] hnext, hnext_next;
  logic [HW-1:0] slot, slot_next;
  logic          from_stash, from_stash_next;
  logic [2:0]    ev, ev_next;

  // Memories and their strobes
  logic [7:0]    edit_mem [LINE_SIZE];
  logic [7:0]    stash_mem [LINE_SIZE];
  logic [7:0]    hist_mem [HISTORY_DEPTH * LINE_SIZE];
  logic [LW-1:0] hist_len [HISTORY_DEPTH];
  logic [7:0]    edit_rd, stash_rd, hist_rd;
  logic          edit_we, stash_we, hist_we, hlen_we;
  logic [LW-1:0] edit_wa, edit_ra;
  logic [7:0]    edit_wd;
  logic [AW-1:0] hist_a;

  // Output register strobes
  logic          out_free, out_load;
  logic [2:0]    o_kind;
  logic [7:0]    o_char;
  logic [LW-1:0] o_cur, o_len;
  logic          o_last;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && !rst;
  assign hist_a   = AW'(slot) * AW'(LINE_SIZE) + AW'(idx);

  // Slot of the entry 'back' steps behind the next write position
  function automatic logic [HW-1:0] slot_of(input logic [HW-1:0] nxt, input logic [HW:0] back);
    logic [HW+1:0] t;
    if (back > {1'b0, nxt}) t = {2'b00, nxt} + (HW+2)'(HISTORY_DEPTH) - {1'b0, back};
    else t = {2'b00, nxt} - {1'b0, back};
    return t[HW-1:0];
  endfunction

  // Next state and datapath
  always_comb begin
    logic [LW-1:0] hl;
    logic [HW-1:0] sl1;
    state_next      = state;
    cur_next        = cur;
    len_next        = len;
    idx_next        = idx;
    ldn_next        = ldn;
    stash_len_next  = stash_len;
    depth_next      = depth;
    hcount_next     = hcount;
    hnext_next      = hnext;
    slot_next       = slot;
    from_stash_next = from_stash;
    ev_next         = ev;
    edit_we = 1'b0;  edit_wa = idx;  edit_wd = edit_rd;  edit_ra = idx;
    stash_we = 1'b0; hist_we = 1'b0; hlen_we = 1'b0;
    out_load = 1'b0; o_kind = ev; o_char = '0; o_cur = cur; o_len = len; o_last = 1'b1;
    sl1 = '0;
    hl  = '0;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        ev_next    = EV_REDRAW;
        state_next = ST_FIN;
        unique case (cmd)
          CMD_HOME:  cur_next = '0;
          CMD_END:   cur_next = len;
          CMD_LEFT:  if (cur != '0) cur_next = cur - 1'b1; else ev_next = EV_NONE;
          CMD_RIGHT: if (cur < len) cur_next = cur + 1'b1; else ev_next = EV_NONE;
          CMD_CLRSCR: ev_next = (len == '0) ? EV_CLEAR : EV_NONE;
          CMD_CANCEL: begin
            ev_next = EV_ABANDON; len_next = '0; cur_next = '0; depth_next = '0;
          end
          CMD_INSERT: begin
            if (len < room) begin
              idx_next   = len;
              state_next = (len > cur) ? ST_INS_RD : ST_INS_PUT;
            end
          end
          CMD_BKSP: begin
            if (cur != '0) begin
              cur_next = cur - 1'b1; idx_next = cur - 1'b1; state_next = ST_REM_CHK;
            end else ev_next = EV_NONE;
          end
          CMD_DELETE: begin
            idx_next = cur; state_next = ST_REM_CHK;
          end
          CMD_ENTER: begin
            idx_next = '0;
            if (len == '0) begin
              ev_next = EV_EMPTY; depth_next = '0;
            end else begin
              sl1 = slot_of(hnext, (HW+1)'(1));
              if (hcount != '0 && hist_len[sl1] == len) begin
                slot_next = sl1; state_next = ST_CMP_RD;
              end else begin
                slot_next = hnext; state_next = ST_CPY_RD;
              end
            end
          end
          CMD_BACK: begin
            if (depth < hcount) begin
              idx_next = '0;
              if (depth != '0) begin
                depth_next = depth + 1'b1; state_next = ST_LOAD_SEL;
              end else if (len == '0) begin
                stash_len_next = '0; depth_next = depth + 1'b1; state_next = ST_LOAD_SEL;
              end else state_next = ST_STASH_RD;
            end
          end
          CMD_FWD: begin
            if (depth != '0) begin
              depth_next = depth - 1'b1; state_next = ST_LOAD_SEL;
            end
          end
          default: ev_next = EV_NONE;
        endcase
      end
      // Insert: shift the tail up one place
      ST_INS_RD: begin
        edit_ra = idx - 1'b1; state_next = ST_INS_WR;
      end
      ST_INS_WR: begin
        edit_we = 1'b1; edit_wa = idx; edit_wd = edit_rd;
        idx_next = idx - 1'b1;
        state_next = ((idx - 1'b1) > cur) ? ST_INS_RD : ST_INS_PUT;
      end
      ST_INS_PUT: begin
        edit_we = 1'b1; edit_wa = cur; edit_wd = kbyte;
        cur_next = cur + 1'b1; len_next = len + 1'b1; state_next = ST_FIN;
      end
      // Remove: shift the tail down one place
      ST_REM_CHK: begin
        if (idx >= len) state_next = ST_FIN;
        else if ({1'b0, idx} + 1'b1 < {1'b0, len}) state_next = ST_REM_RD;
        else begin
          len_next = len - 1'b1; state_next = ST_FIN;
        end
      end
      ST_REM_RD: begin
        edit_ra = idx + 1'b1; state_next = ST_REM_WR;
      end
      ST_REM_WR: begin
        edit_we = 1'b1; edit_wa = idx; edit_wd = edit_rd;
        idx_next = idx + 1'b1;
        if ({1'b0, idx} + 2'd2 < {1'b0, len}) state_next = ST_REM_RD;
        else begin
          len_next = len - 1'b1; state_next = ST_FIN;
        end
      end
      // Repeat check against the newest entry
      ST_CMP_RD: state_next = ST_CMP_CHK;
      ST_CMP_CHK: begin
        if (edit_rd != hist_rd) begin
          idx_next = '0; slot_next = hnext; state_next = ST_CPY_RD;
        end else if (idx == len - 1'b1) begin
          idx_next = '0; state_next = ST_EM_RD;
        end else begin
          idx_next = idx + 1'b1; state_next = ST_CMP_RD;
        end
      end
      // Copy the line into the history ring
      ST_CPY_RD: state_next = ST_CPY_WR;
      ST_CPY_WR: begin
        hist_we = 1'b1;
        if (idx == len - 1'b1) begin
          hlen_we = 1'b1;
          hnext_next = (hnext == HW'(HISTORY_DEPTH - 1)) ? '0 : hnext + 1'b1;
          if (hcount < (HW+1)'(HISTORY_DEPTH)) hcount_next = hcount + 1'b1;
          idx_next = '0; state_next = ST_EM_RD;
        end else begin
          idx_next = idx + 1'b1; state_next = ST_CPY_RD;
        end
      end
      // Stash the line being edited
      ST_STASH_RD: state_next = ST_STASH_WR;
      ST_STASH_WR: begin
        stash_we = 1'b1;
        if (idx == len - 1'b1) begin
          stash_len_next = len; depth_next = depth + 1'b1;
          idx_next = '0; state_next = ST_LOAD_SEL;
        end else begin
          idx_next = idx + 1'b1; state_next = ST_STASH_RD;
        end
      end
      // Pick the source for a recall and clip it to the room
      ST_LOAD_SEL: begin
        idx_next = '0;
        if (depth == '0) begin
          from_stash_next = 1'b1; hl = stash_len;
        end else begin
          from_stash_next = 1'b0;
          slot_next = slot_of(hnext, depth);
          hl = hist_len[slot_of(hnext, depth)];
        end
        ldn_next = (hl > room) ? room : hl;
        if (((hl > room) ? room : hl) == '0) begin
          len_next = '0; cur_next = '0; state_next = ST_FIN;
        end else state_next = ST_LOAD_RD;
      end
      ST_LOAD_RD: state_next = ST_LOAD_WR;
      ST_LOAD_WR: begin
        edit_we = 1'b1; edit_wa = idx;
        edit_wd = from_stash ? stash_rd : hist_rd;
        if (idx == ldn - 1'b1) begin
          len_next = ldn; cur_next = ldn; state_next = ST_FIN;
        end else begin
          idx_next = idx + 1'b1; state_next = ST_LOAD_RD;
        end
      end
      // Emit the committed line
      ST_EM_RD: state_next = ST_EM_OUT;
      ST_EM_OUT: begin
        if (out_free) begin
          out_load = 1'b1; o_kind = EV_CHAR; o_char = edit_rd;
          o_cur = '0; o_len = '0; o_last = (idx == len - 1'b1);
          if (idx == len - 1'b1) begin
            len_next = '0; cur_next = '0; depth_next = '0; state_next = ST_IDLE;
          end else begin
            idx_next = idx + 1'b1; state_next = ST_EM_RD;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load = 1'b1; state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0; len <= '0; depth <= '0; hcount <= '0; hnext <= '0;
      stash_len <= '0; out_valid <= 1'b0;
    end else begin
      cur <= cur_next; len <= len_next; depth <= depth_next;
      hcount <= hcount_next; hnext <= hnext_next; stash_len <= stash_len_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk) begin
    idx <= idx_next; ldn <= ldn_next; slot <= slot_next;
    from_stash <= from_stash_next; ev <= ev_next;
    if (accept) begin
      cmd   <= dec_cmd;
      kbyte <= key_byte;
    end
    if (out_load) begin
      event_kind  <= o_kind;
      char_out    <= o_char;
      cursor_pos  <= 6'(o_cur);
      line_length <= 6'(o_len);
      last        <= o_last;
    end
  end

  // Edit line memory
  always_ff @(posedge clk) begin
    if (edit_we) edit_mem[edit_wa] <= edit_wd;
    edit_rd <= edit_mem[edit_ra];
  end

  // Stash memory
  always_ff @(posedge clk) begin
    if (stash_we) stash_mem[idx] <= edit_rd;
    stash_rd <= stash_mem[idx];
  end

  // History ring
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_a] <= edit_rd;
    hist_rd <= hist_mem[hist_a];
  end

  // History entry lengths
  always_ff @(posedge clk) begin
    if (hlen_we) hist_len[hnext] <= len;
  end

  // Checks
  a_cur_in_line: assert property (@(posedge clk) disable iff (rst) cur <= len)
    else $error("cursor beyond line end");
  a_len_cap: assert property (@(posedge clk) disable iff (rst) len <= LW'(LINE_SIZE - 1))
    else $error("line longer than buffer");
  a_depth_cap: assert property (@(posedge clk) disable iff (rst)
      depth <= hcount && hcount <= (HW+1)'(HISTORY_DEPTH))
    else $error("browse depth or history count out of range");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
      accept |=> state == ST_DISPATCH)
    else $error("accepted item not dispatched");

endmodule

// File: rtl/core/lae_decode.sv
// ESC / CSI decoder: keeps the escape state and the saturating CSI parameter,
// and classifies each byte into a command. Depends on lae_pkg.
`timescale 1ns / 1ps

module lae_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        key_byte,
  output lae_pkg::cmd_t     cmd
);
  import lae_pkg::*;

  esc_t        esc;
  esc_t        esc_next;
  logic [15:0] param;
  logic [15:0] param_next;
  logic        is_digit;
  logic [19:0] param_mul;

  assign is_digit  = (key_byte >= 8'h30) && (key_byte <= 8'h39);
  // param * 10 + digit, saturated
  assign param_mul = {1'b0, param, 3'b000} + {3'b000, param, 1'b0}
                   + {16'd0, key_byte[3:0]};

  // Classify the byte and work out the next decoder state
  always_comb begin
    cmd        = CMD_NONE;
    esc_next   = esc;
    param_next = param;
    unique case (esc)
      ESC_SEEN: begin
        esc_next   = (key_byte == 8'h5b) ? ESC_CSI : ESC_TEXT;
        param_next = '0;
      end
      ESC_CSI: begin
        if (is_digit) begin
          param_next = (param_mul > {4'd0, CSI_MAX}) ? CSI_MAX : param_mul[15:0];
        end else begin
          esc_next = ESC_TEXT;
          unique case (key_byte)
            8'h41: cmd = CMD_BACK;
            8'h42: cmd = CMD_FWD;
            8'h43: cmd = CMD_RIGHT;
            8'h44: cmd = CMD_LEFT;
            8'h48: cmd = CMD_HOME;
            8'h46: cmd = CMD_END;
            8'h7e: begin
              if (param == 16'd3) cmd = CMD_DELETE;
              else if (param == 16'd1 || param == 16'd7) cmd = CMD_HOME;
              else if (param == 16'd4 || param == 16'd8) cmd = CMD_END;
            end
            default: cmd = CMD_NONE;
          endcase
        end
      end
      default: begin
        priority if (key_byte == KEY_ESC) esc_next = ESC_SEEN;
        else if (key_byte == KEY_CR || key_byte == KEY_LF) cmd = CMD_ENTER;
        else if (key_byte == KEY_CTL_C) cmd = CMD_CANCEL;
        else if (key_byte == KEY_CTL_A) cmd = CMD_HOME;
        else if (key_byte == KEY_CTL_E) cmd = CMD_END;
        else if (key_byte == KEY_CTL_L) cmd = CMD_CLRSCR;
        else if (key_byte == KEY_BS || key_byte == KEY_DEL) cmd = CMD_BKSP;
        else if ((key_byte >= KEY_SPACE && key_byte < KEY_DEL) || key_byte >= KEY_LAT1)
          cmd = CMD_INSERT;
        else cmd = CMD_NONE;
      end
    endcase
  end

  // Decoder state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      esc   <= ESC_TEXT;
      param <= '0;
    end else if (accept) begin
      esc   <= esc_next;
      param <= param_next;
    end
  end

endmodule
